/* rtl/fpe_pkg.sv */
// Shared types and constants for the framed packet encoder.
`timescale 1ns / 1ps
package fpe_pkg;

  // Default build options
  localparam int DEF_MAX_WORDS         = 11;
  localparam int DEF_SEND_LENGTH_BYTE  = 0;
  localparam int DEF_HAS_FAN_ROUTE     = 1;
  localparam int DEF_HAS_PROTECT_ROUTE = 1;
  localparam int CMD_FIFO_DEPTH        = 2;

  // Frame constants
  localparam logic [7:0]  SYNC_BYTE_0 = 8'hA5;
  localparam logic [7:0]  SYNC_BYTE_1 = 8'h5A;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // Configuration register map
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_OPERATE_TYPE      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAIN_DEVICE_ID    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FAN_DEVICE_ID     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTECT_DEVICE_ID = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAIN_PORT         = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FAN_PORT          = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTECT_PORT      = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_ENABLE        = 4'd7;

  typedef enum logic [1:0] {
    CMD_ERR,
    CMD_HDR,
    CMD_WORD
  } cmd_kind_t;

  // One entry of the command queue: everything the back end needs for one item
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  port;
    logic [7:0]  len;
    logic [7:0]  ftype;
    logic [7:0]  dev;
    logic [7:0]  tgt;
    logic [3:0]  cnt;
    logic        oper;
    logic        has_word;
    logic        last;
    logic        crc_app;
    logic [15:0] word;
  } fpe_cmd_t;

endpackage

/* rtl/fpe_if.sv */
// Channel interfaces: item input, result output and configuration writes.
`timescale 1ns / 1ps
interface fpe_item_if;
  logic        valid;
  logic        ready;
  logic        frame_start;
  logic [7:0]  dev_id;
  logic [7:0]  frame_type;
  logic [7:0]  target;
  logic [3:0]  word_count;
  logic [15:0] data_word;
  modport source (output valid, frame_start, dev_id, frame_type, target, word_count,
                  data_word, input ready);
  modport sink (input valid, frame_start, dev_id, frame_type, target, word_count,
                data_word, output ready);
endinterface

interface fpe_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] port_id;
  logic       frame_last;
  logic       route_error;
  modport source (output valid, out_byte, port_id, frame_last, route_error, input ready);
  modport sink (input valid, out_byte, port_id, frame_last, route_error, output ready);
endinterface

interface fpe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpe_pkg::CFG_INDEX_W-1:0] index;
  logic [fpe_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/framed_packet_encoder_crc16_top.sv */
// Top level of the framed packet encoder with CRC16 XMODEM.
//
//  channel  role    payload
//  item     sink    frame_start, dev_id, frame_type, target, word_count, data_word
//  result   source  out_byte, port_id, frame_last, route_error (one per frame byte)
//  cfg      sink    index, data (register write, always ready)
//
//  One result byte per cycle from the serializer while the result side is ready; a data
//  word item gives two bytes. A start item gives 6 to 8 header bytes, plus 2 for a
//  word and 2 for a closing CRC. The first result of an item passes through the
//  command queue and the output register. Synchronous reset clears frame state and
//  the queue and loads register defaults. The 2-entry command queue lets item intake
//  run while the result side stalls.
`timescale 1ns / 1ps
module framed_packet_encoder_crc16_top #(
  parameter int MAX_WORDS         = fpe_pkg::DEF_MAX_WORDS,
  parameter int SEND_LENGTH_BYTE  = fpe_pkg::DEF_SEND_LENGTH_BYTE,
  parameter int HAS_FAN_ROUTE     = fpe_pkg::DEF_HAS_FAN_ROUTE,
  parameter int HAS_PROTECT_ROUTE = fpe_pkg::DEF_HAS_PROTECT_ROUTE
) (
  input  logic         clk,
  input  logic         rst,
  fpe_item_if.sink     item,
  fpe_result_if.source result,
  fpe_cfg_if.sink      cfg
);
  import fpe_pkg::*;

  logic     push;
  fpe_cmd_t push_cmd;
  logic     fifo_full;
  logic     pop;
  logic     head_valid;
  fpe_cmd_t head;

  fpe_front #(
    .MAX_WORDS        (MAX_WORDS),
    .HAS_FAN_ROUTE    (HAS_FAN_ROUTE),
    .HAS_PROTECT_ROUTE(HAS_PROTECT_ROUTE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .fifo_full(fifo_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  fpe_cmd_fifo #(
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  fpe_back #(
    .SEND_LENGTH_BYTE(SEND_LENGTH_BYTE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* rtl/fpe_cmd_fifo.sv */
// Small command queue between the front end and the byte serializer.
`timescale 1ns / 1ps
module fpe_cmd_fifo #(
  parameter int DEPTH = fpe_pkg::CMD_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fpe_pkg::fpe_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output fpe_pkg::fpe_cmd_t head
);
  import fpe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fpe_cmd_t        entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/fpe_front.sv */
// Front end: config registers, device routing, frame tracking and command build.
`timescale 1ns / 1ps
module fpe_front #(
  parameter int MAX_WORDS         = fpe_pkg::DEF_MAX_WORDS,
  parameter int HAS_FAN_ROUTE     = fpe_pkg::DEF_HAS_FAN_ROUTE,
  parameter int HAS_PROTECT_ROUTE = fpe_pkg::DEF_HAS_PROTECT_ROUTE
) (
  input  logic              clk,
  input  logic              rst,
  fpe_item_if.sink          item,
  fpe_cfg_if.sink           cfg,
  input  logic              fifo_full,
  output logic              push,
  output fpe_pkg::fpe_cmd_t cmd
);
  import fpe_pkg::*;

  logic [7:0] operate_type;
  logic [7:0] main_device_id;
  logic [7:0] fan_device_id;
  logic [7:0] protect_device_id;
  logic [2:0] main_port;
  logic [2:0] fan_port;
  logic [2:0] protect_port;
  logic       crc_enable;

  logic       in_frame, in_frame_next;
  logic [3:0] words_left, words_left_next;
  logic       dropping, dropping_next;
  logic [2:0] latched_port, latched_port_next;

  logic       acc;
  logic       found;
  logic [2:0] route_port;
  logic       bad;
  logic       oper;
  logic       last_word;
  logic [3:0] cnt_m1;
  logic [3:0] wl_m1;

  assign cfg.ready  = 1'b1;
  assign item.ready = !fifo_full;
  assign acc        = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      operate_type      <= 8'd0;
      main_device_id    <= 8'd0;
      fan_device_id     <= 8'd1;
      protect_device_id <= 8'd2;
      main_port         <= 3'd0;
      fan_port          <= 3'd1;
      protect_port      <= 3'd2;
      crc_enable        <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OPERATE_TYPE:      operate_type      <= cfg.data;
        REG_MAIN_DEVICE_ID:    main_device_id    <= cfg.data;
        REG_FAN_DEVICE_ID:     fan_device_id     <= cfg.data;
        REG_PROTECT_DEVICE_ID: protect_device_id <= cfg.data;
        REG_MAIN_PORT:         main_port         <= cfg.data[2:0];
        REG_FAN_PORT:          fan_port          <= cfg.data[2:0];
        REG_PROTECT_PORT:      protect_port      <= cfg.data[2:0];
        REG_CRC_ENABLE:        crc_enable        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Device match priority: main, fan, protect
  always_comb begin
    found      = 1'b1;
    route_port = main_port;
    priority if (item.dev_id == main_device_id) begin
      route_port = main_port;
    end else if (HAS_FAN_ROUTE != 0 && item.dev_id == fan_device_id) begin
      route_port = fan_port;
    end else if (HAS_PROTECT_ROUTE != 0 && item.dev_id == protect_device_id) begin
      route_port = protect_port;
    end else begin
      found      = 1'b0;
      route_port = 3'd0;
    end
  end

  assign bad    = !found || (item.word_count > 4'(MAX_WORDS));
  assign oper   = (item.frame_type == operate_type);
  assign cnt_m1 = item.word_count - 4'd1;
  assign wl_m1  = words_left - 4'd1;

  always_comb begin
    cmd.kind     = CMD_WORD;
    cmd.port     = latched_port;
    cmd.len      = 8'd3 + {3'b000, item.word_count, 1'b0} + {7'd0, oper}
                   + (crc_enable ? 8'd2 : 8'd0);
    cmd.ftype    = item.frame_type;
    cmd.dev      = item.dev_id;
    cmd.tgt      = item.target;
    cmd.cnt      = item.word_count;
    cmd.oper     = oper;
    cmd.has_word = 1'b0;
    cmd.last     = 1'b0;
    cmd.crc_app  = 1'b0;
    cmd.word     = item.data_word;
    last_word    = 1'b0;
    push              = 1'b0;
    in_frame_next     = in_frame;
    words_left_next   = words_left;
    dropping_next     = dropping;
    latched_port_next = latched_port;

    if (item.frame_start) begin
      if (bad) begin
        // dropped frame: one error result, swallow the remaining words
        cmd.kind        = CMD_ERR;
        cmd.port        = 3'd0;
        cmd.last        = 1'b1;
        push            = acc;
        words_left_next = (item.word_count != 4'd0) ? cnt_m1 : 4'd0;
        in_frame_next   = (item.word_count > 4'd1);
        dropping_next   = (item.word_count > 4'd1);
      end else begin
        last_word         = (item.word_count <= 4'd1);
        cmd.kind          = CMD_HDR;
        cmd.port          = route_port;
        cmd.has_word      = (item.word_count != 4'd0);
        cmd.last          = last_word;
        cmd.crc_app       = last_word && crc_enable;
        push              = acc;
        latched_port_next = route_port;
        words_left_next   = (item.word_count != 4'd0) ? cnt_m1 : 4'd0;
        in_frame_next     = (item.word_count > 4'd1);
        dropping_next     = 1'b0;
      end
    end else if (in_frame) begin
      words_left_next = wl_m1;
      in_frame_next   = (wl_m1 != 4'd0);
      if (dropping) begin
        dropping_next = (wl_m1 != 4'd0);
      end else begin
        last_word    = (wl_m1 == 4'd0);
        cmd.kind     = CMD_WORD;
        cmd.has_word = 1'b1;
        cmd.last     = last_word;
        cmd.crc_app  = last_word && crc_enable;
        push         = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      words_left   <= 4'd0;
      dropping     <= 1'b0;
      latched_port <= 3'd0;
    end else if (acc) begin
      in_frame     <= in_frame_next;
      words_left   <= words_left_next;
      dropping     <= dropping_next;
      latched_port <= latched_port_next;
    end
  end

endmodule

/* rtl/fpe_back.sv */
// Back end: walks each queued command byte by byte, runs the CRC, drives results.
`timescale 1ns / 1ps
module fpe_back #(
  parameter int SEND_LENGTH_BYTE = fpe_pkg::DEF_SEND_LENGTH_BYTE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  fpe_pkg::fpe_cmd_t head,
  output logic              pop,
  fpe_result_if.source      result
);
  import fpe_pkg::*;

  typedef enum logic [3:0] {
    ST_START,
    ST_SYNC0,
    ST_SYNC1,
    ST_LEN,
    ST_TYPE,
    ST_DEV,
    ST_TGT,
    ST_CNTCOPY,
    ST_OPCNT,
    ST_WHI,
    ST_WLO,
    ST_CHI,
    ST_CLO,
    ST_ERR,
    ST_DONE
  } step_t;

  step_t       step;
  step_t       first;
  step_t       cur;
  step_t       nxt;
  step_t       after_tgt, after_copy, after_op, after_word;
  logic [15:0] crc;
  logic [15:0] crc_in;
  logic [15:0] crc_next;
  logic [7:0]  cur_byte;
  logic        covered;
  logic        fire;
  logic        done;

  logic        o_valid;
  logic [7:0]  o_byte;
  logic [2:0]  o_port;
  logic        o_last;
  logic        o_err;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  always_comb begin
    unique case (head.kind)
      CMD_ERR:  first = ST_ERR;
      CMD_HDR:  first = ST_SYNC0;
      CMD_WORD: first = ST_WHI;
      default:  first = ST_ERR;
    endcase
  end

  assign cur        = (step == ST_START) ? first : step;
  assign after_word = head.crc_app ? ST_CHI : ST_DONE;
  assign after_op   = head.has_word ? ST_WHI : after_word;
  assign after_copy = head.oper ? ST_OPCNT : after_op;
  assign after_tgt  = (SEND_LENGTH_BYTE != 0) ? ST_CNTCOPY : after_copy;

  always_comb begin
    cur_byte = 8'h00;
    covered  = 1'b0;
    nxt      = ST_DONE;
    unique case (cur)
      ST_SYNC0:   begin cur_byte = SYNC_BYTE_0;     nxt = ST_SYNC1; end
      ST_SYNC1:   begin cur_byte = SYNC_BYTE_1;     nxt = ST_LEN; end
      ST_LEN:     begin cur_byte = head.len;        nxt = ST_TYPE; end
      ST_TYPE:    begin cur_byte = head.ftype;      nxt = ST_DEV;     covered = 1'b1; end
      ST_DEV:     begin cur_byte = head.dev;        nxt = ST_TGT;     covered = 1'b1; end
      ST_TGT:     begin cur_byte = head.tgt;        nxt = after_tgt;  covered = 1'b1; end
      ST_CNTCOPY: begin cur_byte = {4'd0, head.cnt}; nxt = after_copy; covered = 1'b1; end
      ST_OPCNT:   begin cur_byte = {4'd0, head.cnt}; nxt = after_op;   covered = 1'b1; end
      ST_WHI:     begin cur_byte = head.word[15:8]; nxt = ST_WLO;     covered = 1'b1; end
      ST_WLO:     begin cur_byte = head.word[7:0];  nxt = after_word; covered = 1'b1; end
      ST_CHI:     begin cur_byte = crc[15:8];       nxt = ST_CLO; end
      ST_CLO:     begin cur_byte = crc[7:0];        nxt = ST_DONE; end
      ST_ERR:     begin cur_byte = 8'h00;           nxt = ST_DONE; end
      default:    begin cur_byte = 8'h00;           nxt = ST_DONE; end
    endcase
  end

  // CRC restarts with every header
  assign crc_in   = (cur == ST_SYNC0) ? 16'h0000 : crc;
  assign crc_next = covered ? crc_byte(crc_in, cur_byte) : crc_in;

  assign fire = head_valid && (!o_valid || result.ready);
  assign done = (nxt == ST_DONE);
  assign pop  = fire && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= ST_START;
      crc     <= 16'h0000;
      o_valid <= 1'b0;
      o_byte  <= 8'h00;
      o_port  <= 3'd0;
      o_last  <= 1'b0;
      o_err   <= 1'b0;
    end else if (fire) begin
      step    <= done ? ST_START : nxt;
      crc     <= crc_next;
      o_valid <= 1'b1;
      o_byte  <= cur_byte;
      o_port  <= (head.kind == CMD_ERR) ? 3'd0 : head.port;
      o_last  <= done && head.last;
      o_err   <= (head.kind == CMD_ERR);
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  assign result.valid       = o_valid;
  assign result.out_byte    = o_byte;
  assign result.port_id     = o_port;
  assign result.frame_last  = o_last;
  assign result.route_error = o_err;

endmodule

/* rtl/fpe_checker.sv */
// Port-level assertions for the encoder, bound to the top level.
`timescale 1ns / 1ps
module fpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] out_byte,
  input logic [2:0] port_id,
  input logic       frame_last,
  input logic       route_error
);

  // An error result is a lone, closed, zero result
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && route_error |-> frame_last && out_byte == 8'h00 && port_id == 3'd0)
    else $error("error result with nonzero payload or open frame");

  // Nothing comes out straight after reset: queue and output are empty
  a_quiet_after_rst: assert property (@(posedge clk)
    rst |=> !rsp_valid ##1 !rsp_valid)
    else $error("result shown too soon after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(port_id)
      && $stable(frame_last) && $stable(route_error))
    else $error("stalled result changed");

endmodule

bind framed_packet_encoder_crc16_top fpe_checker u_fpe_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (result.valid),
  .rsp_ready  (result.ready),
  .out_byte   (result.out_byte),
  .port_id    (result.port_id),
  .frame_last (result.frame_last),
  .route_error(result.route_error)
);

/* test/fpe_frame_checker.sv */
// Frame checker: predicts the serialized byte stream of the encoder and compares it.
`timescale 1ns / 1ps
module fpe_frame_checker #(
  parameter int MAX_WORDS         = fpe_pkg::DEF_MAX_WORDS,
  parameter int SEND_LENGTH_BYTE  = fpe_pkg::DEF_SEND_LENGTH_BYTE,
  parameter int HAS_FAN_ROUTE     = fpe_pkg::DEF_HAS_FAN_ROUTE,
  parameter int HAS_PROTECT_ROUTE = fpe_pkg::DEF_HAS_PROTECT_ROUTE
) (
  input  logic  clk,
  input  logic  rst,
  fpe_item_if   item,
  fpe_result_if result,
  fpe_cfg_if    cfg,
  output int    mismatch_count,
  output int    bytes_pending
);
  import fpe_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] port_id;
    logic       frame_last;
    logic       route_error;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  // register shadow
  logic [7:0] operate_type, main_id, fan_id, protect_id;
  logic [2:0] main_port, fan_port, protect_port;
  logic       crc_en;

  // frame state
  logic       in_frame, dropping;
  logic [3:0] words_left;
  logic [15:0] crc_acc;
  logic [2:0] frame_port;

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit covered);
    frame_byte_t e;
    e.out_byte    = b;
    e.port_id     = frame_port;
    e.frame_last  = 1'b0;
    e.route_error = 1'b0;
    expected_bytes.push_back(e);
    if (covered) crc_acc = crc16_update(crc_acc, b);
  endtask

  task automatic close_frame();
    logic [15:0] c;
    c = crc_acc;
    if (crc_en) begin
      push_byte(c[15:8], 1'b0);
      push_byte(c[7:0], 1'b0);
    end
    expected_bytes[expected_bytes.size() - 1].frame_last = 1'b1;
    in_frame   = 1'b0;
    words_left = 4'd0;
    dropping   = 1'b0;
  endtask

  task automatic encode_item(input logic fs, input logic [7:0] dev, input logic [7:0] typ,
                             input logic [7:0] tgt, input logic [3:0] cnt,
                             input logic [15:0] word);
    bit          found;
    bit          oper;
    logic [2:0]  port;
    logic [7:0]  len;
    frame_byte_t err;
    if (fs) begin
      oper  = (typ == operate_type);
      found = 1'b1;
      port  = 3'd0;
      if (dev == main_id) port = main_port;
      else if (HAS_FAN_ROUTE != 0 && dev == fan_id) port = fan_port;
      else if (HAS_PROTECT_ROUTE != 0 && dev == protect_id) port = protect_port;
      else found = 1'b0;

      if (!found || int'(cnt) > MAX_WORDS) begin
        // dropped frame: one error byte, remaining words swallowed
        words_left = (cnt != 4'd0) ? cnt - 4'd1 : 4'd0;
        in_frame   = (words_left != 4'd0);
        dropping   = in_frame;
        crc_acc    = 16'h0000;
        err.out_byte    = 8'h00;
        err.port_id     = 3'd0;
        err.frame_last  = 1'b1;
        err.route_error = 1'b1;
        expected_bytes.push_back(err);
        return;
      end

      frame_port = port;
      crc_acc    = 16'h0000;
      dropping   = 1'b0;
      len = 8'(3 + 2 * int'(cnt) + (oper ? 1 : 0) + (crc_en ? 2 : 0));
      push_byte(SYNC_BYTE_0, 1'b0);
      push_byte(SYNC_BYTE_1, 1'b0);
      push_byte(len, 1'b0);
      push_byte(typ, 1'b1);
      push_byte(dev, 1'b1);
      push_byte(tgt, 1'b1);
      if (SEND_LENGTH_BYTE != 0) push_byte({4'h0, cnt}, 1'b1);
      if (oper) push_byte({4'h0, cnt}, 1'b1);
      if (cnt == 4'd0) begin
        close_frame();
        return;
      end
      words_left = cnt;
      in_frame   = 1'b1;
    end else if (!in_frame) begin
      return;
    end

    if (dropping) begin
      words_left = words_left - 4'd1;
      if (words_left == 4'd0) begin
        in_frame = 1'b0;
        dropping = 1'b0;
      end
      return;
    end

    push_byte(word[15:8], 1'b1);
    push_byte(word[7:0], 1'b1);
    words_left = words_left - 4'd1;
    if (words_left == 4'd0) close_frame();
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      operate_type   = 8'd0;
      main_id        = 8'd0;
      fan_id         = 8'd1;
      protect_id     = 8'd2;
      main_port      = 3'd0;
      fan_port       = 3'd1;
      protect_port   = 3'd2;
      crc_en         = 1'b1;
      in_frame       = 1'b0;
      dropping       = 1'b0;
      words_left     = 4'd0;
      crc_acc        = 16'h0000;
      frame_port     = 3'd0;
      mismatch_count = 0;
      expected_bytes.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_OPERATE_TYPE:      operate_type = cfg.data;
          REG_MAIN_DEVICE_ID:    main_id      = cfg.data;
          REG_FAN_DEVICE_ID:     fan_id       = cfg.data;
          REG_PROTECT_DEVICE_ID: protect_id   = cfg.data;
          REG_MAIN_PORT:         main_port    = cfg.data[2:0];
          REG_FAN_PORT:          fan_port     = cfg.data[2:0];
          REG_PROTECT_PORT:      protect_port = cfg.data[2:0];
          REG_CRC_ENABLE:        crc_en       = cfg.data[0];
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        encode_item(item.frame_start, item.dev_id, item.frame_type, item.target,
                    item.word_count, item.data_word);
      if (result.valid && result.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0h port_id %0d frame_last %0b route_error %0b",
                 result.out_byte, result.port_id, result.frame_last, result.route_error);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          compare_field("out_byte", want.out_byte, result.out_byte);
          compare_field("port_id", {5'd0, want.port_id}, {5'd0, result.port_id});
          compare_field("frame_last", {7'd0, want.frame_last}, {7'd0, result.frame_last});
          compare_field("route_error", {7'd0, want.route_error}, {7'd0, result.route_error});
        end
      end
    end
    bytes_pending = expected_bytes.size();
  end

endmodule

/* test/framed_packet_encoder_crc16_top_test.sv */
// Testbench top: drives frames and register writes into the encoder and gives the verdict.
`timescale 1ns / 1ps
module framed_packet_encoder_crc16_top_test;
  import fpe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   mismatches;
  int   pending;

  // stimulus shaping
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  logic [7:0] cur_op      = 8'd0;
  logic [7:0] cur_main    = 8'd0;
  logic [7:0] cur_fan     = 8'd1;
  logic [7:0] cur_protect = 8'd2;

  fpe_item_if   item_ch();
  fpe_result_if result_ch();
  fpe_cfg_if    cfg_ch();

  framed_packet_encoder_crc16_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  fpe_frame_checker frame_check (
    .clk            (clk),
    .rst            (rst),
    .item           (item_ch),
    .result         (result_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatches),
    .bytes_pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  task automatic send_item(input logic fs, input logic [7:0] dev, input logic [7:0] typ,
                           input logic [7:0] tgt, input logic [3:0] cnt,
                           input logic [15:0] word);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.frame_start <= fs;
    item_ch.dev_id      <= dev;
    item_ch.frame_type  <= typ;
    item_ch.target      <= tgt;
    item_ch.word_count  <= cnt;
    item_ch.data_word   <= word;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // start transaction plus n_items-1 continuation transactions with random payload
  task automatic send_frame(input logic [7:0] dev, input logic [7:0] typ, input logic [7:0] tgt,
                            input logic [3:0] cnt, input int n_items);
    send_item(1'b1, dev, typ, tgt, cnt, rand_word());
    for (int i = 1; i < n_items; i++)
      send_item(1'b0, rand_byte(), rand_byte(), rand_byte(), 4'($urandom), rand_word());
    items_sent += n_items;
  endtask

  task automatic random_frame();
    logic [7:0] dev;
    logic [7:0] typ;
    logic [3:0] cnt;
    int         r;
    int         n;
    r = $urandom_range(99);
    if (r < 25) dev = cur_main;
    else if (r < 45) dev = cur_fan;
    else if (r < 65) dev = cur_protect;
    else dev = rand_byte();
    typ = ($urandom_range(99) < 30) ? cur_op : rand_byte();
    cnt = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
    n = (cnt == 4'd0) ? 1 : int'(cnt);
    // cut some frames short; the next start transaction restarts the encoder
    if (cnt > 4'd1 && $urandom_range(99) < 12) n = $urandom_range(int'(cnt) - 1, 1);
    send_frame(dev, typ, rand_byte(), cnt, n);
    if (n == int'(cnt) && $urandom_range(99) < 8)
      send_item(1'b0, rand_byte(), rand_byte(), rand_byte(), 4'($urandom), rand_word());
  endtask

  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // port and enable registers get junk in the unused upper bits
  task automatic apply_settings(input logic [7:0] op, input logic [7:0] main_id,
                                input logic [7:0] fan_id, input logic [7:0] protect_id,
                                input logic [2:0] mp, input logic [2:0] fp,
                                input logic [2:0] pp, input logic crc);
    cur_op      = op;
    cur_main    = main_id;
    cur_fan     = fan_id;
    cur_protect = protect_id;
    write_reg(REG_OPERATE_TYPE, op);
    write_reg(REG_MAIN_DEVICE_ID, main_id);
    write_reg(REG_FAN_DEVICE_ID, fan_id);
    write_reg(REG_PROTECT_DEVICE_ID, protect_id);
    write_reg(REG_MAIN_PORT, {5'($urandom), mp});
    write_reg(REG_FAN_PORT, {5'($urandom), fp});
    write_reg(REG_PROTECT_PORT, {5'($urandom), pp});
    write_reg(REG_CRC_ENABLE, {7'($urandom), crc});
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    @(posedge clk);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
  endtask

  task automatic run_phase(input int n_items);
    int first;
    first = items_sent;
    while (items_sent - first < n_items) random_frame();
    // clean zero-word frame so the encoder ends the phase idle
    send_frame(cur_main, rand_byte(), rand_byte(), 4'd0, 1);
    drain();
  endtask

  initial begin
    logic [7:0] shared_id;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.frame_start = 1'b0;
    item_ch.dev_id      = 8'd0;
    item_ch.frame_type  = 8'd0;
    item_ch.target      = 8'd0;
    item_ch.word_count  = 4'd0;
    item_ch.data_word   = 16'd0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at the reset register values
    send_item(1'b1, 8'h00, 8'h00, 8'h00, 4'd0, 16'hFFFF);   // operate type, no data words
    send_item(1'b1, 8'h01, 8'hFF, 8'h80, 4'd1, 16'hFFFF);   // fan route, one word
    send_item(1'b1, 8'h02, 8'h55, 8'hFF, 4'd2, 16'h0000);   // protect route
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 4'hF, 16'h8001);
    send_item(1'b1, 8'hFF, 8'h00, 8'h00, 4'd3, 16'h1234);   // unknown device, rest swallowed
    send_item(1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 16'h5678);
    send_item(1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 16'h9ABC);
    send_item(1'b1, 8'h00, 8'h01, 8'h00, 4'd12, 16'hFFFF);  // count one past max
    send_item(1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 16'h0000);
    send_item(1'b1, 8'h01, 8'h00, 8'h7F, 4'd5, 16'hA55A);   // restart while dropping
    send_item(1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 16'h5AA5);
    send_item(1'b1, 8'h02, 8'hFE, 8'h01, 4'd1, 16'h00FF);   // abandon open frame
    send_item(1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 16'hFFFF);   // no frame open: ignored
    send_item(1'b1, 8'h00, 8'h00, 8'hAA, 4'd11, 16'hFFFF);  // max words, operate type
    repeat (10) send_item(1'b0, 8'h00, 8'h00, 8'h00, 4'd0, rand_word());
    drain();

    set_idling(0, 0);
    apply_settings(8'hFF, 8'hFF, 8'h00, 8'h80, 3'd7, 3'd0, 3'd5, 1'b0);
    run_phase(15);

    // long receiver hold-off while the sender keeps pushing full frames
    @(posedge clk);
    hold_left = 300;
    send_frame(cur_main, rand_byte(), rand_byte(), 4'd11, 11);
    send_frame(cur_fan, cur_op, rand_byte(), 4'd11, 11);
    drain();

    // fan id shadows main id: main must win
    shared_id = rand_byte();
    set_idling(58, 0);
    apply_settings(rand_byte(), shared_id, shared_id, ~shared_id, 3'($urandom), 3'($urandom),
                   3'($urandom), 1'b1);
    run_phase(15);

    // protect id shadows fan id
    set_idling(0, 58);
    apply_settings(8'h00, 8'h10, 8'h20, 8'h20, 3'd0, 3'd7, 3'd3, 1'b1);
    run_phase(15);

    set_idling(15, 15);
    apply_settings(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 3'($urandom),
                   3'($urandom), 3'($urandom), 1'b0);
    run_phase(15);

    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
